[rtl/i2c_master_byte_engine_core_defines.svh]
// ----------------------------------------------------------------------------
// I2C byte engine assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_ENGINE_CORE_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication.
`define I2CMBE_ASSERT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define I2CMBE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[rtl/i2cmbe_pkg.sv]
// ----------------------------------------------------------------------------
// I2C byte engine package
// Shared types, command codes and sizes.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned PHASE_W = 5;

  localparam logic [TICK_W-1:0] PHASE_TICKS_RST = 16'd50;

  // Command codes on the input channel
  localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STOP  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WRITE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

  // Queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Active operation, one-hot
  typedef enum logic [4:0] {
    OP_IDLE  = 5'b00001,
    OP_START = 5'b00010,
    OP_STOP  = 5'b00100,
    OP_WRITE = 5'b01000,
    OP_READ  = 5'b10000
  } op_e;

  // Classified tick
  typedef struct packed {
    op_e               op;      // OP_IDLE: tick only
    logic              bad;     // undefined command code
    logic [BYTE_W-1:0] tx_byte;
    logic              send_ack;
    logic              sda_in;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_xfer_t;

  typedef struct packed {
    logic              scl_level;
    logic              sda_level;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] rx_byte;
    logic              ack_seen;
    logic              rejected;
  } res_t;

  // Phases per operation
  function automatic logic [PHASE_W-1:0] op_length(op_e op);
    logic [PHASE_W-1:0] len;
    case (op)
      OP_START: len = 5'd3;
      OP_STOP:  len = 5'd3;
      OP_WRITE: len = 5'd27;
      OP_READ:  len = 5'd20;
      default:  len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

[rtl/i2cmbe_in_if.sv]
// ----------------------------------------------------------------------------
// I2C byte engine input channel
// One tick per transfer: command, byte, ack choice and sampled SDA.
// ----------------------------------------------------------------------------
interface i2cmbe_in_if;
  logic                             valid;
  logic                             ready;
  logic [i2cmbe_pkg::CMD_W-1:0]     cmd;
  logic [i2cmbe_pkg::BYTE_W-1:0]    tx_byte;
  logic                             send_ack;
  logic                             sda_in;

  modport source (output valid, cmd, tx_byte, send_ack, sda_in, input ready);
  modport sink   (input valid, cmd, tx_byte, send_ack, sda_in, output ready);
endinterface

[rtl/i2cmbe_out_if.sv]
// ----------------------------------------------------------------------------
// I2C byte engine result channel
// One result per tick: bus drives and status.
// ----------------------------------------------------------------------------
interface i2cmbe_out_if;
  logic                             valid;
  logic                             ready;
  logic                             scl_level;
  logic                             sda_level;
  logic                             busy_res;
  logic                             done_res;
  logic [i2cmbe_pkg::BYTE_W-1:0]    rx_byte;
  logic                             ack_seen;
  logic                             rejected;

  modport source (output valid, scl_level, sda_level, busy_res, done_res, rx_byte,
                  ack_seen, rejected, input ready);
  modport sink   (input valid, scl_level, sda_level, busy_res, done_res, rx_byte,
                  ack_seen, rejected, output ready);
endinterface

[rtl/i2cmbe_cfg_if.sv]
// ----------------------------------------------------------------------------
// I2C byte engine configuration channel
// Write port for the phase length register.
// ----------------------------------------------------------------------------
interface i2cmbe_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [i2cmbe_pkg::TICK_W-1:0]    data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[rtl/i2cmbe_front.sv]
// ----------------------------------------------------------------------------
// I2C byte engine front end
// Takes ticks from the input channel, decodes the command code, pushes.
// ----------------------------------------------------------------------------
module i2cmbe_front (
  i2cmbe_in_if.sink             in_ch,
  output i2cmbe_pkg::q_xfer_t   push_o,
  input  logic                  push_ready_i
);

  i2cmbe_pkg::item_t item;

  always_comb begin
    item.tx_byte  = in_ch.tx_byte;
    item.send_ack = in_ch.send_ack;
    item.sda_in   = in_ch.sda_in;
    item.bad      = 1'b0;
    case (in_ch.cmd)
      i2cmbe_pkg::CMD_TICK:  item.op = i2cmbe_pkg::OP_IDLE;
      i2cmbe_pkg::CMD_START: item.op = i2cmbe_pkg::OP_START;
      i2cmbe_pkg::CMD_STOP:  item.op = i2cmbe_pkg::OP_STOP;
      i2cmbe_pkg::CMD_WRITE: item.op = i2cmbe_pkg::OP_WRITE;
      i2cmbe_pkg::CMD_READ:  item.op = i2cmbe_pkg::OP_READ;
      default: begin
        item.op  = i2cmbe_pkg::OP_IDLE;
        item.bad = 1'b1;
      end
    endcase
  end

  assign push_o.valid = in_ch.valid;
  assign push_o.item  = item;
  assign in_ch.ready  = push_ready_i;

endmodule

[rtl/i2cmbe_queue.sv]
// ----------------------------------------------------------------------------
// I2C byte engine tick queue
// Small FIFO of decoded ticks between front and back.
// ----------------------------------------------------------------------------
`include "i2c_master_byte_engine_core_defines.svh"

module i2cmbe_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  i2cmbe_pkg::q_xfer_t   push_i,
  output logic                  push_ready_o,
  output i2cmbe_pkg::q_xfer_t   pop_o,
  input  logic                  pop_ready_i
);

  localparam logic [i2cmbe_pkg::Q_PTR_W-1:0] PtrLast =
    i2cmbe_pkg::Q_PTR_W'(i2cmbe_pkg::Q_DEPTH - 1);
  localparam logic [i2cmbe_pkg::Q_CNT_W-1:0] CntFull =
    i2cmbe_pkg::Q_CNT_W'(i2cmbe_pkg::Q_DEPTH);

  i2cmbe_pkg::item_t                   mem_q [i2cmbe_pkg::Q_DEPTH];
  logic [i2cmbe_pkg::Q_PTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [i2cmbe_pkg::Q_PTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [i2cmbe_pkg::Q_CNT_W-1:0]      cnt_q, cnt_d;
  logic                                do_push, do_pop;

  assign push_ready_o = (cnt_q != CntFull);
  assign do_push      = push_i.valid && push_ready_o;
  assign pop_o.valid  = (cnt_q != '0);
  assign pop_o.item   = mem_q[rd_ptr_q];
  assign do_pop       = pop_o.valid && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.item;
    end
  end

  `I2CMBE_ASSERT(a_q_cnt_range, 1'b1, cnt_q <= CntFull, "queue count out of range")
  `I2CMBE_ASSERT(a_q_ptr_gap, cnt_q == '0 || cnt_q == CntFull, wr_ptr_q == rd_ptr_q,
                 "queue pointers disagree with count")
  `I2CMBE_ASSERT_NEXT(a_q_push_only, do_push && !do_pop, cnt_q == $past(cnt_q) + 1'b1,
                      "queue count missed a push")

endmodule

[rtl/i2cmbe_back.sv]
// ----------------------------------------------------------------------------
// I2C byte engine sequencer
// Runs the bus phase sequencer one tick per item, registers the result.
// ----------------------------------------------------------------------------
`include "i2c_master_byte_engine_core_defines.svh"

module i2cmbe_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  i2cmbe_cfg_if.sink            cfg_ch,
  input  i2cmbe_pkg::q_xfer_t   pop_i,
  output logic                  pop_ready_o,
  i2cmbe_out_if.source          out_ch
);

  typedef struct packed {
    logic                          scl;
    logic                          sda;
    logic [i2cmbe_pkg::BYTE_W-1:0] shift;
  } drive_t;

  // idx mod 3 for a 5-bit index: weights of 2^k mod 3 are 1,2,1,2,1
  function automatic logic [1:0] mod3(logic [i2cmbe_pkg::PHASE_W-1:0] idx);
    logic [2:0] s;
    logic [1:0] r;
    s = 3'(idx[0]) + 3'(idx[2]) + 3'(idx[4]) + {2'(idx[1]) + 2'(idx[3]), 1'b0};
    case (s)
      3'd0, 3'd3, 3'd6: r = 2'd0;
      3'd1, 3'd4, 3'd7: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  // Drives applied as a phase begins
  function automatic drive_t phase_begin(i2cmbe_pkg::op_e op,
                                         logic [i2cmbe_pkg::PHASE_W-1:0] idx,
                                         drive_t cur, logic sack);
    drive_t d;
    d = cur;
    case (op)
      i2cmbe_pkg::OP_START: begin
        if (idx == 5'd0) begin
          d.sda = 1'b1;
          d.scl = 1'b1;
        end else if (idx == 5'd1) begin
          d.sda = 1'b0;
        end else begin
          d.scl = 1'b0;
        end
      end
      i2cmbe_pkg::OP_STOP: begin
        if (idx == 5'd0) begin
          d.sda = 1'b0;
          d.scl = 1'b0;
        end else if (idx == 5'd1) begin
          d.scl = 1'b1;
        end else begin
          d.sda = 1'b1;
        end
      end
      i2cmbe_pkg::OP_WRITE: begin
        if (idx < 5'd24) begin
          case (mod3(idx))
            2'd0: d.scl = 1'b0;
            2'd1: begin
              d.sda   = cur.shift[7];
              d.shift = {cur.shift[6:0], 1'b0};
            end
            default: d.scl = 1'b1;
          endcase
        end else if (idx == 5'd24) begin
          d.scl = 1'b0;
          d.sda = 1'b1;
        end else if (idx == 5'd25) begin
          d.scl = 1'b1;
        end else begin
          d.scl = 1'b0;
        end
      end
      i2cmbe_pkg::OP_READ: begin
        if (idx < 5'd16) begin
          if (idx == 5'd0) begin
            d.sda = 1'b1;
          end
          d.scl = idx[0];
        end else if (idx == 5'd16) begin
          d.scl = 1'b0;
        end else if (idx == 5'd17) begin
          d.sda = !sack;
        end else if (idx == 5'd18) begin
          d.scl = 1'b1;
        end else begin
          d.scl = 1'b0;
        end
      end
      default: d = cur;
    endcase
    return d;
  endfunction

  logic [i2cmbe_pkg::TICK_W-1:0]   phase_ticks_q;
  i2cmbe_pkg::op_e                 op_q, op_d;
  logic [i2cmbe_pkg::PHASE_W-1:0]  idx_q, idx_d;
  logic [i2cmbe_pkg::TICK_W-1:0]   tick_q, tick_d;
  logic [i2cmbe_pkg::BYTE_W-1:0]   shift_q, shift_d;
  logic                            ack_q, ack_d;
  logic                            scl_q, scl_d;
  logic                            sda_q, sda_d;
  logic                            sack_q, sack_d;
  logic [i2cmbe_pkg::BYTE_W-1:0]   rx_q, rx_d;
  i2cmbe_pkg::res_t                res_q, res_d;
  logic                            res_valid_q;
  logic                            step;

  assign cfg_ch.ready = 1'b1;
  assign pop_ready_o  = !res_valid_q || out_ch.ready;
  assign step         = pop_i.valid && pop_ready_o;

  always_comb begin
    drive_t                         drv;
    i2cmbe_pkg::item_t              it;
    logic                           start;
    logic [i2cmbe_pkg::TICK_W-1:0]  limit;
    logic [i2cmbe_pkg::TICK_W-1:0]  tc;
    logic [i2cmbe_pkg::PHASE_W-1:0] idx_n;

    it      = pop_i.item;
    op_d    = op_q;
    idx_d   = idx_q;
    tick_d  = tick_q;
    ack_d   = ack_q;
    sack_d  = sack_q;
    rx_d    = rx_q;
    drv     = '{scl: scl_q, sda: sda_q, shift: shift_q};
    res_d   = '0;
    limit   = (phase_ticks_q == '0) ? 16'd1 : phase_ticks_q;
    idx_n   = '0;

    start = !it.bad && (it.op != i2cmbe_pkg::OP_IDLE) && (op_q == i2cmbe_pkg::OP_IDLE);
    res_d.rejected = it.bad || ((it.op != i2cmbe_pkg::OP_IDLE) &&
                                (op_q != i2cmbe_pkg::OP_IDLE));

    if (start) begin
      op_d   = it.op;
      idx_d  = '0;
      tick_d = '0;
      if (it.op == i2cmbe_pkg::OP_WRITE) begin
        drv.shift = it.tx_byte;
      end
      if (it.op == i2cmbe_pkg::OP_READ) begin
        drv.shift = '0;
        sack_d    = it.send_ack;
      end
      drv = phase_begin(op_d, 5'd0, drv, sack_d);
    end

    res_d.busy_res  = (op_d != i2cmbe_pkg::OP_IDLE);
    res_d.scl_level = drv.scl;
    res_d.sda_level = drv.sda;

    tc = tick_d + 1'b1;
    if (res_d.busy_res) begin
      if (tc >= limit || tc == '0) begin
        // phase ends: sample on its last tick
        if (op_d == i2cmbe_pkg::OP_WRITE && idx_d == 5'd25) begin
          ack_d = it.sda_in;
        end
        if (op_d == i2cmbe_pkg::OP_READ) begin
          if (idx_d < 5'd16 && idx_d[0]) begin
            drv.shift = {drv.shift[6:0], it.sda_in};
          end
          if (idx_d == 5'd19) begin
            rx_d = drv.shift;
          end
        end
        idx_n  = idx_d + 1'b1;
        tick_d = '0;
        if (idx_n >= i2cmbe_pkg::op_length(op_d)) begin
          op_d           = i2cmbe_pkg::OP_IDLE;
          idx_d          = '0;
          res_d.done_res = 1'b1;
        end else begin
          idx_d = idx_n;
          drv   = phase_begin(op_d, idx_n, drv, sack_d);
        end
      end else begin
        tick_d = tc;
      end
    end

    scl_d          = drv.scl;
    sda_d          = drv.sda;
    shift_d        = drv.shift;
    res_d.rx_byte  = rx_d;
    res_d.ack_seen = ack_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= i2cmbe_pkg::PHASE_TICKS_RST;
      op_q          <= i2cmbe_pkg::OP_IDLE;
      idx_q         <= '0;
      tick_q        <= '0;
      shift_q       <= '0;
      ack_q         <= 1'b0;
      scl_q         <= 1'b1;
      sda_q         <= 1'b1;
      sack_q        <= 1'b0;
      rx_q          <= '0;
      res_valid_q   <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        phase_ticks_q <= cfg_ch.data;
      end
      if (step) begin
        op_q    <= op_d;
        idx_q   <= idx_d;
        tick_q  <= tick_d;
        shift_q <= shift_d;
        ack_q   <= ack_d;
        scl_q   <= scl_d;
        sda_q   <= sda_d;
        sack_q  <= sack_d;
        rx_q    <= rx_d;
      end
      if (step) begin
        res_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_ch.valid     = res_valid_q;
  assign out_ch.scl_level = res_q.scl_level;
  assign out_ch.sda_level = res_q.sda_level;
  assign out_ch.busy_res  = res_q.busy_res;
  assign out_ch.done_res  = res_q.done_res;
  assign out_ch.rx_byte   = res_q.rx_byte;
  assign out_ch.ack_seen  = res_q.ack_seen;
  assign out_ch.rejected  = res_q.rejected;

  `I2CMBE_ASSERT(a_op_onehot, 1'b1, $onehot(op_q), "active operation not one-hot")
  `I2CMBE_ASSERT(a_idle_clear, op_q == i2cmbe_pkg::OP_IDLE,
                 idx_q == '0 && tick_q == '0, "phase counters not clear while idle")
  `I2CMBE_ASSERT(a_idx_bound, op_q != i2cmbe_pkg::OP_IDLE,
                 idx_q < i2cmbe_pkg::op_length(op_q), "phase index past operation end")
  `I2CMBE_ASSERT(a_done_busy, res_valid_q && res_q.done_res, res_q.busy_res,
                 "done reported on an idle tick")

endmodule

[rtl/i2c_master_byte_engine_core.sv]
// ----------------------------------------------------------------------------
// I2C master byte engine
// Byte-level I2C master: start, stop, write and read byte as bus phases.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Payload                                         Per transfer
//  -------  ---  ----------------------------------------------  -------------------
//  cfg_ch   in   data[15:0] ticks per bus phase                  phase length write
//  in_ch    in   cmd, tx_byte, send_ack, sda_in                  one bus tick
//  out_ch   out  scl_level, sda_level, busy_res, done_res,
//                rx_byte, ack_seen, rejected                     one result per tick
//
//  One tick is taken per clock cycle while the queue has room; each tick gives
//  exactly one result. The sequencer step (phase counter add and compare, phase
//  decode) is combinational; a tick passes the queue, then the result register.
//  Reset: phase length 50, SCL and SDA released, no operation active.
//  A 2-entry queue sits between decode and sequencer, and the result register
//  is refilled in the cycle it drains, so a stalled result side blocks input
//  only once the queue is full.
//
module i2c_master_byte_engine_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  i2cmbe_cfg_if.sink    cfg_ch,
  i2cmbe_in_if.sink     in_ch,
  i2cmbe_out_if.source  out_ch
);

  // Decoded ticks into the queue
  i2cmbe_pkg::q_xfer_t push;
  logic                push_ready;

  // Queue head toward the sequencer
  i2cmbe_pkg::q_xfer_t pop;
  logic                pop_ready;

  // Front: decode the command code, flag undefined codes
  i2cmbe_front u_front (
    .in_ch        (in_ch),
    .push_o       (push),
    .push_ready_i (push_ready)
  );

  // Tick queue: lets front and sequencer stall independently
  i2cmbe_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .pop_o        (pop),
    .pop_ready_i  (pop_ready)
  );

  // Back: phase sequencer, bit shifter, sampling and result register
  i2cmbe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_ch      (cfg_ch),
    .pop_i       (pop),
    .pop_ready_o (pop_ready),
    .out_ch      (out_ch)
  );

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C master byte engine testbench
// Drives bus ticks with start, stop, write and read commands. An in-bench
// model of the phase sequencer predicts the drives and status of every tick.
// A short table of directed rows comes first, then random traffic under
// several phase lengths, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb;

  // Undefined command codes, all of them must be rejected
  localparam logic [i2cmbe_pkg::CMD_W-1:0] CMD_RSVD5 = 3'd5;
  localparam logic [i2cmbe_pkg::CMD_W-1:0] CMD_RSVD6 = 3'd6;
  localparam logic [i2cmbe_pkg::CMD_W-1:0] CMD_RSVD7 = 3'd7;

  // Phase numbers where samples are taken
  localparam logic [i2cmbe_pkg::PHASE_W-1:0] WR_ACK_PH  = 5'd25;  // write: slave ack
  localparam logic [i2cmbe_pkg::PHASE_W-1:0] RD_LAST_PH = 5'd19;  // read: byte handed over

  localparam int unsigned ITEMS_PER_SPAN = 50;
  localparam int unsigned SETTLE_CYC     = 4;   // result path: queue, then result register
  localparam int unsigned CYCLE_LIMIT    = 200000;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e                     kind;
    logic [i2cmbe_pkg::TICK_W-1:0] ticks;   // phase length for a config row
    logic [i2cmbe_pkg::CMD_W-1:0]  cmd;
    logic [i2cmbe_pkg::BYTE_W-1:0] tx;
    logic                          ack;
    logic                          sda;     // also used for the filler ticks
    int unsigned                   fill;    // plain ticks that follow the row
    logic                          typed;   // use the literal result below
    i2cmbe_pkg::res_t              want;
  } plan_row_t;

  logic clk_i;
  logic rst_ni;

  i2cmbe_cfg_if cfg_ch ();
  i2cmbe_in_if  in_ch ();
  i2cmbe_out_if out_ch ();

  i2c_master_byte_engine_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Sequencer model state
  logic [i2cmbe_pkg::TICK_W-1:0]  ph_ticks;
  i2cmbe_pkg::op_e                eng_op;
  logic [i2cmbe_pkg::PHASE_W-1:0] eng_phase;
  logic [i2cmbe_pkg::TICK_W-1:0]  eng_count;
  logic [i2cmbe_pkg::BYTE_W-1:0]  eng_shift;
  logic                           eng_ackf;
  logic                           eng_scl;
  logic                           eng_sda;
  logic                           eng_ack_drv;
  logic [i2cmbe_pkg::BYTE_W-1:0]  eng_rx;

  i2cmbe_pkg::res_t drive_q[$];   // predicted drives and status, oldest first
  plan_row_t        plan_q[$];
  int unsigned      mismatches;
  int unsigned      ticks_sent;
  int unsigned      results_seen;
  int unsigned      cmds_done;
  int unsigned      cmds_rejected;
  int unsigned      cycle_cnt = 0;
  logic             in_burst;
  logic             out_burst;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Drives that take effect when a phase begins
  function automatic void enter_phase();
    case (eng_op)
      i2cmbe_pkg::OP_START: begin
        if (eng_phase == 0) begin
          eng_sda = 1'b1;
          eng_scl = 1'b1;
        end else if (eng_phase == 1) eng_sda = 1'b0;
        else eng_scl = 1'b0;
      end
      i2cmbe_pkg::OP_STOP: begin
        if (eng_phase == 0) begin
          eng_sda = 1'b0;
          eng_scl = 1'b0;
        end else if (eng_phase == 1) eng_scl = 1'b1;
        else eng_sda = 1'b1;
      end
      i2cmbe_pkg::OP_WRITE: begin
        if (eng_phase < 24) begin
          case (eng_phase % 3)
            0: eng_scl = 1'b0;
            1: begin
              eng_sda   = eng_shift[7];
              eng_shift = {eng_shift[6:0], 1'b0};
            end
            default: eng_scl = 1'b1;
          endcase
        end else if (eng_phase == 24) begin
          eng_scl = 1'b0;
          eng_sda = 1'b1;   // release for the slave ack
        end else if (eng_phase == WR_ACK_PH) eng_scl = 1'b1;
        else eng_scl = 1'b0;
      end
      i2cmbe_pkg::OP_READ: begin
        if (eng_phase < 16) begin
          if (eng_phase == 0) eng_sda = 1'b1;
          eng_scl = eng_phase[0];
        end else if (eng_phase == 16) eng_scl = 1'b0;
        else if (eng_phase == 17) eng_sda = ~eng_ack_drv;
        else if (eng_phase == 18) eng_scl = 1'b1;
        else eng_scl = 1'b0;
      end
      default: ;
    endcase
  endfunction

  // One bus tick through the sequencer model
  function automatic i2cmbe_pkg::res_t engine_tick(logic [i2cmbe_pkg::CMD_W-1:0] cmd,
                                                   logic [i2cmbe_pkg::BYTE_W-1:0] tx,
                                                   logic ack, logic sda);
    i2cmbe_pkg::res_t               r;
    logic [i2cmbe_pkg::TICK_W-1:0]  span;
    logic [i2cmbe_pkg::PHASE_W-1:0] n_phases;
    r    = '0;
    span = (ph_ticks == 0) ? 16'd1 : ph_ticks;
    if (cmd != i2cmbe_pkg::CMD_TICK) begin
      if (eng_op != i2cmbe_pkg::OP_IDLE || cmd > i2cmbe_pkg::CMD_READ) begin
        r.rejected = 1'b1;
      end else begin
        case (cmd)
          i2cmbe_pkg::CMD_START: eng_op = i2cmbe_pkg::OP_START;
          i2cmbe_pkg::CMD_STOP:  eng_op = i2cmbe_pkg::OP_STOP;
          i2cmbe_pkg::CMD_WRITE: eng_op = i2cmbe_pkg::OP_WRITE;
          default:               eng_op = i2cmbe_pkg::OP_READ;
        endcase
        eng_phase = '0;
        eng_count = '0;
        if (cmd == i2cmbe_pkg::CMD_WRITE) eng_shift = tx;
        if (cmd == i2cmbe_pkg::CMD_READ) begin
          eng_shift   = '0;
          eng_ack_drv = ack;
        end
        enter_phase();
      end
    end
    r.busy_res  = (eng_op != i2cmbe_pkg::OP_IDLE);
    r.scl_level = eng_scl;
    r.sda_level = eng_sda;
    if (r.busy_res) begin
      eng_count = eng_count + 1'b1;
      if (eng_count >= span || eng_count == 0) begin
        // samples use SDA on the last tick of the phase
        if (eng_op == i2cmbe_pkg::OP_WRITE && eng_phase == WR_ACK_PH) eng_ackf = sda;
        if (eng_op == i2cmbe_pkg::OP_READ) begin
          if (eng_phase < 16 && eng_phase[0]) eng_shift = {eng_shift[6:0], sda};
          if (eng_phase == RD_LAST_PH) eng_rx = eng_shift;
        end
        case (eng_op)
          i2cmbe_pkg::OP_START, i2cmbe_pkg::OP_STOP: n_phases = 5'd3;
          i2cmbe_pkg::OP_WRITE:                      n_phases = 5'd27;
          default:                                   n_phases = 5'd20;
        endcase
        eng_phase = eng_phase + 1'b1;
        eng_count = '0;
        if (eng_phase >= n_phases) begin
          eng_op     = i2cmbe_pkg::OP_IDLE;
          eng_phase  = '0;
          r.done_res = 1'b1;
        end else begin
          enter_phase();
        end
      end
    end
    r.rx_byte  = eng_rx;
    r.ack_seen = eng_ackf;
    return r;
  endfunction

  function automatic i2cmbe_pkg::res_t bus_res(logic scl, logic sda, logic busy,
                                               logic done,
                                               logic [i2cmbe_pkg::BYTE_W-1:0] rx,
                                               logic ackf, logic rej);
    i2cmbe_pkg::res_t r;
    r.scl_level = scl;
    r.sda_level = sda;
    r.busy_res  = busy;
    r.done_res  = done;
    r.rx_byte   = rx;
    r.ack_seen  = ackf;
    r.rejected  = rej;
    return r;
  endfunction

  function automatic void plan_cfg(logic [i2cmbe_pkg::TICK_W-1:0] ticks);
    plan_row_t row;
    row.kind  = ROW_CFG;
    row.ticks = ticks;
    row.cmd   = i2cmbe_pkg::CMD_TICK;
    row.tx    = '0;
    row.ack   = 1'b0;
    row.sda   = 1'b0;
    row.fill  = 0;
    row.typed = 1'b0;
    row.want  = '0;
    plan_q.push_back(row);
  endfunction

  function automatic void plan_item(logic [i2cmbe_pkg::CMD_W-1:0] cmd,
                                    logic [i2cmbe_pkg::BYTE_W-1:0] tx,
                                    logic ack, logic sda, int unsigned fill,
                                    logic typed, i2cmbe_pkg::res_t want);
    plan_row_t row;
    row.kind  = ROW_TICK;
    row.ticks = '0;
    row.cmd   = cmd;
    row.tx    = tx;
    row.ack   = ack;
    row.sda   = sda;
    row.fill  = fill;
    row.typed = typed;
    row.want  = want;
    plan_q.push_back(row);
  endfunction

  // One tick transfer; the model runs at the accepting edge
  task automatic drive_tick(logic [i2cmbe_pkg::CMD_W-1:0] cmd,
                            logic [i2cmbe_pkg::BYTE_W-1:0] tx, logic ack,
                            logic sda, logic typed, i2cmbe_pkg::res_t fixed);
    int unsigned      gap;
    i2cmbe_pkg::res_t pred;
    if ($urandom_range(0, 49) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.cmd      <= cmd;
    in_ch.tx_byte  <= tx;
    in_ch.send_ack <= ack;
    in_ch.sda_in   <= sda;
    do @(posedge clk_i); while (!in_ch.ready);
    pred = engine_tick(cmd, tx, ack, sda);
    drive_q.push_back(typed ? fixed : pred);
    ticks_sent++;
    if (pred.done_res) cmds_done++;
    if (pred.rejected) cmds_rejected++;
  endtask

  // Stop sending and wait until every predicted result has come back
  task automatic settle_bus();
    in_ch.valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic set_phase_ticks(logic [i2cmbe_pkg::TICK_W-1:0] ticks);
    settle_bus();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= ticks;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    ph_ticks = ticks;
  endtask

  function automatic void field_check(string name, logic [i2cmbe_pkg::BYTE_W-1:0] want,
                                      logic [i2cmbe_pkg::BYTE_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Result side: random stalls, with stretches of full rate
  initial begin : result_ready
    int unsigned stall;
    out_ch.ready <= 1'b0;
    out_burst = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 49) == 0) out_burst = !out_burst;
      stall = out_burst ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  // Compare every result transfer with the oldest prediction
  always @(posedge clk_i) begin : result_check
    i2cmbe_pkg::res_t want;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_cnt, drive_q.size());
      $display("simulation failed");
      $finish;
    end
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (drive_q.size() == 0) begin
        $error("result transfer with nothing expected");
        mismatches++;
      end else begin
        want = drive_q.pop_front();
        field_check("scl_level", i2cmbe_pkg::BYTE_W'(want.scl_level),
                    i2cmbe_pkg::BYTE_W'(out_ch.scl_level));
        field_check("sda_level", i2cmbe_pkg::BYTE_W'(want.sda_level),
                    i2cmbe_pkg::BYTE_W'(out_ch.sda_level));
        field_check("busy_res",  i2cmbe_pkg::BYTE_W'(want.busy_res),
                    i2cmbe_pkg::BYTE_W'(out_ch.busy_res));
        field_check("done_res",  i2cmbe_pkg::BYTE_W'(want.done_res),
                    i2cmbe_pkg::BYTE_W'(out_ch.done_res));
        field_check("rx_byte",   want.rx_byte, out_ch.rx_byte);
        field_check("ack_seen",  i2cmbe_pkg::BYTE_W'(want.ack_seen),
                    i2cmbe_pkg::BYTE_W'(out_ch.ack_seen));
        field_check("rejected",  i2cmbe_pkg::BYTE_W'(want.rejected),
                    i2cmbe_pkg::BYTE_W'(out_ch.rejected));
      end
    end
  end

  initial begin : stimulus
    logic [i2cmbe_pkg::TICK_W-1:0] spans [4];
    logic [i2cmbe_pkg::CMD_W-1:0]  cmd;
    int unsigned                   sel;

    in_ch.valid    <= 1'b0;
    in_ch.cmd      <= i2cmbe_pkg::CMD_TICK;
    in_ch.tx_byte  <= '0;
    in_ch.send_ack <= 1'b0;
    in_ch.sda_in   <= 1'b1;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.data    <= '0;
    mismatches    = 0;
    ticks_sent    = 0;
    results_seen  = 0;
    cmds_done     = 0;
    cmds_rejected = 0;
    in_burst      = 1'b0;

    ph_ticks    = i2cmbe_pkg::PHASE_TICKS_RST;
    eng_op      = i2cmbe_pkg::OP_IDLE;
    eng_phase   = '0;
    eng_count   = '0;
    eng_shift   = '0;
    eng_ackf    = 1'b0;
    eng_scl     = 1'b1;
    eng_sda     = 1'b1;
    eng_ack_drv = 1'b0;
    eng_rx      = '0;

    // Reset phase length: idle tick, undefined codes, then a start that
    // runs its full 3 x 50 ticks with a write rejected along the way
    plan_item(i2cmbe_pkg::CMD_TICK,  8'h00, 1'b0, 1'b0, 0, 1'b1,
              bus_res(1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0));
    plan_item(CMD_RSVD5, 8'hFF, 1'b1, 1'b0, 0, 1'b1,
              bus_res(1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1));
    plan_item(CMD_RSVD6, 8'h00, 1'b0, 1'b1, 0, 1'b1,
              bus_res(1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1));
    plan_item(CMD_RSVD7, 8'hFF, 1'b1, 1'b1, 0, 1'b1,
              bus_res(1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1));
    plan_item(i2cmbe_pkg::CMD_START, 8'h00, 1'b0, 1'b1, 0, 1'b1,
              bus_res(1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0));
    plan_item(i2cmbe_pkg::CMD_WRITE, 8'h5A, 1'b0, 1'b1, 148, 1'b1,
              bus_res(1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1));
    // One tick per phase: byte extremes, ack and nack both ways
    plan_cfg(16'd1);
    plan_item(i2cmbe_pkg::CMD_WRITE, 8'hFF, 1'b0, 1'b1, 26, 1'b0, '0);
    plan_item(i2cmbe_pkg::CMD_WRITE, 8'h00, 1'b0, 1'b0, 25, 1'b0, '0);
    plan_item(i2cmbe_pkg::CMD_READ,  8'h00, 1'b1, 1'b0, 0, 1'b0, '0);   // on the done tick
    plan_item(i2cmbe_pkg::CMD_READ,  8'h00, 1'b1, 1'b1, 19, 1'b0, '0);
    plan_item(i2cmbe_pkg::CMD_READ,  8'h00, 1'b0, 1'b0, 19, 1'b0, '0);
    plan_item(i2cmbe_pkg::CMD_STOP,  8'h00, 1'b0, 1'b1, 2, 1'b0, '0);
    plan_item(i2cmbe_pkg::CMD_START, 8'h00, 1'b0, 1'b1, 2, 1'b0, '0);
    // Zero length counts as one tick
    plan_cfg(16'd0);
    plan_item(i2cmbe_pkg::CMD_WRITE, 8'hA5, 1'b0, 1'b0, 26, 1'b0, '0);
    plan_item(i2cmbe_pkg::CMD_STOP,  8'h00, 1'b0, 1'b1, 2, 1'b0, '0);
    // Longest phase, cut short by a shorter length mid-phase
    plan_cfg(16'hFFFF);
    plan_item(i2cmbe_pkg::CMD_START, 8'h00, 1'b0, 1'b1, 300, 1'b0, '0);
    plan_cfg(16'd1);
    plan_item(i2cmbe_pkg::CMD_TICK,  8'h00, 1'b0, 1'b1, 2, 1'b0, '0);
    plan_cfg(16'd2);
    plan_item(i2cmbe_pkg::CMD_READ,  8'h00, 1'b0, 1'b1, 39, 1'b0, '0);

    wait (rst_ni);
    @(posedge clk_i);

    foreach (plan_q[i]) begin
      if (plan_q[i].kind == ROW_CFG) begin
        set_phase_ticks(plan_q[i].ticks);
      end else begin
        drive_tick(plan_q[i].cmd, plan_q[i].tx, plan_q[i].ack, plan_q[i].sda,
                   plan_q[i].typed, plan_q[i].want);
        repeat (plan_q[i].fill) begin
          drive_tick(i2cmbe_pkg::CMD_TICK, 8'h00, 1'b0, plan_q[i].sda, 1'b0, '0);
        end
      end
    end

    // Random traffic: mostly commands when idle, mostly plain ticks when busy,
    // with some rejected and undefined commands mixed in
    spans[0] = 16'd1;
    spans[1] = 16'd3;
    spans[2] = 16'd0;
    spans[3] = i2cmbe_pkg::TICK_W'($urandom_range(1, 4));
    foreach (spans[p]) begin
      set_phase_ticks(spans[p]);
      for (int n = 0; n < ITEMS_PER_SPAN; n++) begin
        sel = $urandom_range(0, 99);
        cmd = i2cmbe_pkg::CMD_TICK;
        if (eng_op == i2cmbe_pkg::OP_IDLE) begin
          if (sel >= 30) begin
            cmd = i2cmbe_pkg::CMD_W'(i2cmbe_pkg::CMD_START + $urandom_range(0, 3));
          end else if (sel >= 20) begin
            cmd = i2cmbe_pkg::CMD_W'($urandom_range(CMD_RSVD5, CMD_RSVD7));
          end
        end else begin
          if (sel >= 95) begin
            cmd = i2cmbe_pkg::CMD_W'($urandom_range(CMD_RSVD5, CMD_RSVD7));
          end else if (sel >= 88) begin
            cmd = i2cmbe_pkg::CMD_W'(i2cmbe_pkg::CMD_START + $urandom_range(0, 3));
          end
        end
        drive_tick(cmd, i2cmbe_pkg::BYTE_W'($urandom), 1'($urandom), 1'($urandom),
                   1'b0, '0);
      end
    end

    settle_bus();
    repeat (8) @(posedge clk_i);
    $display("%0d ticks sent, %0d results checked", ticks_sent, results_seen);
    $display("%0d commands completed, %0d rejected, phase lengths 0 to 65535",
             cmds_done, cmds_rejected);
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

[i2c_master_byte_engine_core.f]
+incdir+rtl
rtl/i2cmbe_pkg.sv
rtl/i2cmbe_in_if.sv
rtl/i2cmbe_out_if.sv
rtl/i2cmbe_cfg_if.sv
rtl/i2cmbe_front.sv
rtl/i2cmbe_queue.sv
rtl/i2cmbe_back.sv
rtl/i2c_master_byte_engine_core.sv
bench/tb.sv
